@@ hw/rtl/rrct_pkg.sv @@
// ----------------------------------------------------------------------------
// Read request coalescing table package
// Shared types and constants for the controller and the datapath.
// ----------------------------------------------------------------------------
package rrct_pkg;

    localparam int SPC_BITS = 4;
    localparam int SIZE_BITS = 8;
    localparam int SECT_BITS = 4;
    localparam int WARP_ID_BITS = 6;
    localparam int STAMP_BITS = 32;
    localparam int LIMIT_BITS = 6;
    localparam int PADDR_BITS = 4;

    localparam logic [PADDR_BITS-1:0] REG_POLICY = 4'h0;
    localparam logic [PADDR_BITS-1:0] REG_HYBRID = 4'h4;
    localparam logic [PADDR_BITS-1:0] REG_LIMIT = 4'h8;

    localparam logic [1:0] POLICY_OLDEST = 2'd0;
    localparam logic [1:0] POLICY_GREEDY = 2'd1;
    localparam logic [1:0] POLICY_HYBRID = 2'd2;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_POP = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic execute;
        logic out_load;
    } dp_cmd_t;

endpackage

@@ hw/rtl/rrct_if.sv @@
// ----------------------------------------------------------------------------
// Request and result channel interfaces
// Valid/ready channels carrying one transaction each.
// ----------------------------------------------------------------------------
interface rrct_req_if #(
    parameter int ADDR_BITS = 48
);
    logic                 valid;
    logic                 ready;
    logic                 command;
    logic [ADDR_BITS-1:0] address;
    logic [3:0]           space;
    logic [7:0]           req_size;
    logic [3:0]           sectors;
    logic [5:0]           warp;

    modport source (output valid, command, address, space, req_size, sectors, warp,
                    input ready);
    modport sink (input valid, command, address, space, req_size, sectors, warp,
                  output ready);
endinterface

interface rrct_rsp_if #(
    parameter int ADDR_BITS = 48
);
    logic                 valid;
    logic                 ready;
    logic                 accepted;
    logic                 merged;
    logic                 pop_valid;
    logic [ADDR_BITS-1:0] out_address;
    logic [3:0]           out_space;
    logic [7:0]           out_size;
    logic [3:0]           out_sectors;
    logic [63:0]          out_warps;
    logic                 now_empty;

    modport source (output valid, accepted, merged, pop_valid, out_address, out_space,
                    out_size, out_sectors, out_warps, now_empty, input ready);
    modport sink (input valid, accepted, merged, pop_valid, out_address, out_space,
                  out_size, out_sectors, out_warps, now_empty, output ready);
endinterface

@@ hw/rtl/read_request_coalescing_table_unit.sv @@
// ----------------------------------------------------------------------------
// Read request coalescing table
// Merges read requests by key and pops them oldest first or greedy.
//
//  Channel  | Direction | Contents
//  req      | in        | command, address, space, req_size, sectors, warp
//  rsp      | out       | accepted, merged, pop_valid, out_*, now_empty
//  apb      | in        | selection_policy, hybrid_mode, entry_limit
//
// Each transaction passes through capture, then an execute state that
// matches and selects over all slots and registers the result.
// The next request is taken in the cycle its predecessor's result is taken.
// Reset clears slot valid bits, stamp counter and greedy warp; no sweep.
// A stalled result holds the table; no request is taken meanwhile.
// ----------------------------------------------------------------------------
module read_request_coalescing_table_unit
    import rrct_pkg::*;
#(
    parameter int TABLE_DEPTH = 32,
    parameter int WARP_COUNT = 64,
    parameter int ADDR_BITS = 48
)(
    input  logic                  clk,
    input  logic                  rst_n,
    rrct_req_if.sink              req,
    rrct_rsp_if.source            rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic [1:0]            policy_reg;
    logic                  hybrid_reg;
    logic [LIMIT_BITS-1:0] limit_reg;
    dp_cmd_t               cmd;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POLICY_OLDEST;
            hybrid_reg <= 1'b0;
            limit_reg <= LIMIT_BITS'(32);
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (paddr)
                REG_POLICY: policy_reg <= pwdata[1:0];
                REG_HYBRID: hybrid_reg <= pwdata[0];
                REG_LIMIT:  limit_reg <= pwdata[LIMIT_BITS-1:0];
                default:    limit_reg <= limit_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr)
            REG_POLICY: prdata = {30'd0, policy_reg};
            REG_HYBRID: prdata = {31'd0, hybrid_reg};
            REG_LIMIT:  prdata = {26'd0, limit_reg};
            default:    prdata = '0;
        endcase
    end

    rrct_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd)
    );

    rrct_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .WARP_COUNT  (WARP_COUNT),
        .ADDR_BITS   (ADDR_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .policy        (policy_reg),
        .hybrid        (hybrid_reg),
        .limit         (limit_reg),
        .req_command   (req.command),
        .req_address   (req.address),
        .req_space     (req.space),
        .req_size      (req.req_size),
        .req_sectors   (req.sectors),
        .req_warp      (req.warp),
        .rsp_accepted  (rsp.accepted),
        .rsp_merged    (rsp.merged),
        .rsp_pop_valid (rsp.pop_valid),
        .rsp_address   (rsp.out_address),
        .rsp_space     (rsp.out_space),
        .rsp_size      (rsp.out_size),
        .rsp_sectors   (rsp.out_sectors),
        .rsp_warps     (rsp.out_warps),
        .rsp_empty     (rsp.now_empty)
    );

endmodule

@@ hw/rtl/rrct_ctrl.sv @@
// ----------------------------------------------------------------------------
// Coalescing table controller
// Sequences capture, table update and result hand-over for one transaction.
// ----------------------------------------------------------------------------
module rrct_ctrl
    import rrct_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    req_valid,
    output logic    req_ready,
    output logic    rsp_valid,
    input  logic    rsp_ready,
    output dp_cmd_t cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (rsp_ready)
                begin
                    state_next = req_valid ? ST_EXEC : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready = 1'b0;
        rsp_valid = 1'b0;
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                cmd.capture = req_valid;
            end
            ST_EXEC:
            begin
                cmd.execute = 1'b1;
                cmd.out_load = 1'b1;
            end
            ST_OUT:
            begin
                rsp_valid = 1'b1;
                req_ready = rsp_ready;
                cmd.capture = rsp_ready && req_valid;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EXEC |=> state_reg == ST_OUT)
        else $error("Execute did not lead to result.");
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("Result dropped while stalled.");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> cmd.execute)
        else $error("Captured transaction not executed.");

endmodule

@@ hw/rtl/rrct_datapath.sv @@
// ----------------------------------------------------------------------------
// Coalescing table datapath
// Slot storage, key match, free slot search and pop selection.
// ----------------------------------------------------------------------------
module rrct_datapath
    import rrct_pkg::*;
#(
    parameter int TABLE_DEPTH = 32,
    parameter int WARP_COUNT = 64,
    parameter int ADDR_BITS = 48
)(
    input  logic                    clk,
    input  logic                    rst_n,
    input  dp_cmd_t                 cmd,
    input  logic [1:0]              policy,
    input  logic                    hybrid,
    input  logic [LIMIT_BITS-1:0]   limit,
    input  logic                    req_command,
    input  logic [ADDR_BITS-1:0]    req_address,
    input  logic [SPC_BITS-1:0]     req_space,
    input  logic [SIZE_BITS-1:0]    req_size,
    input  logic [SECT_BITS-1:0]    req_sectors,
    input  logic [WARP_ID_BITS-1:0] req_warp,
    output logic                    rsp_accepted,
    output logic                    rsp_merged,
    output logic                    rsp_pop_valid,
    output logic [ADDR_BITS-1:0]    rsp_address,
    output logic [SPC_BITS-1:0]     rsp_space,
    output logic [SIZE_BITS-1:0]    rsp_size,
    output logic [SECT_BITS-1:0]    rsp_sectors,
    output logic [63:0]             rsp_warps,
    output logic                    rsp_empty
);

    localparam int IDX_BITS = $clog2(TABLE_DEPTH);
    localparam int CNT_BITS = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_BITS = ADDR_BITS + SPC_BITS;
    localparam int LEAVES = 1 << IDX_BITS;

    logic [TABLE_DEPTH-1:0]  valid_reg;
    logic [KEY_BITS-1:0]     key_reg [TABLE_DEPTH];
    logic [SIZE_BITS-1:0]    size_reg [TABLE_DEPTH];
    logic [SECT_BITS-1:0]    sect_reg [TABLE_DEPTH];
    logic [WARP_COUNT-1:0]   warps_reg [TABLE_DEPTH];
    logic [STAMP_BITS-1:0]   stamp_reg [TABLE_DEPTH];
    logic [STAMP_BITS-1:0]   counter_reg;
    logic [WARP_ID_BITS-1:0] greedy_reg;

    logic                    cmd_reg;
    logic [KEY_BITS-1:0]     key_in_reg;
    logic [SIZE_BITS-1:0]    size_in_reg;
    logic [SECT_BITS-1:0]    sect_in_reg;
    logic [WARP_ID_BITS-1:0] warp_in_reg;

    logic                    hit;
    logic [IDX_BITS-1:0]     hit_idx;
    logic                    has_free;
    logic [IDX_BITS-1:0]     free_idx;
    logic [CNT_BITS-1:0]     count;
    logic [CNT_BITS:0]       eff_limit;
    logic                    do_alloc;
    logic                    old_found;
    logic [IDX_BITS-1:0]     old_idx;
    logic                    gr_found;
    logic [IDX_BITS-1:0]     gr_idx;
    logic                    low_found;
    logic [IDX_BITS-1:0]     low_idx;
    logic [WARP_ID_BITS-1:0] low_warp;
    logic [WARP_ID_BITS-1:0] slot_lw [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]  slot_lw_ok;
    logic                    old_node_ok [2*LEAVES];
    logic [IDX_BITS-1:0]     old_node_idx [2*LEAVES];
    logic [STAMP_BITS-1:0]   old_node_stamp [2*LEAVES];
    logic                    low_node_ok [2*LEAVES];
    logic [IDX_BITS-1:0]     low_node_idx [2*LEAVES];
    logic [WARP_ID_BITS-1:0] low_node_warp [2*LEAVES];
    logic                    use_greedy;
    logic                    fallback;
    logic                    pick_ok;
    logic                    pick_new_greedy;
    logic [IDX_BITS-1:0]     pick_idx;
    logic [TABLE_DEPTH-1:0]  valid_after;
    logic [WARP_ID_BITS-1:0] wsat;

    always_comb
    begin
        wsat = (32'(req_warp) >= WARP_COUNT) ? WARP_ID_BITS'(WARP_COUNT - 1) : req_warp;
    end

    always_comb
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            slot_lw[i] = '0;
            slot_lw_ok[i] = 1'b0;
            for (int w = WARP_COUNT - 1; w >= 0; w--)
            begin
                if (warps_reg[i][w])
                begin
                    slot_lw[i] = WARP_ID_BITS'(w);
                    slot_lw_ok[i] = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        hit = 1'b0;
        hit_idx = '0;
        has_free = 1'b0;
        free_idx = '0;
        gr_found = 1'b0;
        gr_idx = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (valid_reg[i])
            begin
                if (!hit && key_reg[i] == key_in_reg)
                begin
                    hit = 1'b1;
                    hit_idx = IDX_BITS'(i);
                end
                if (!gr_found && warps_reg[i][greedy_reg])
                begin
                    gr_found = 1'b1;
                    gr_idx = IDX_BITS'(i);
                end
            end
            else if (!has_free)
            begin
                has_free = 1'b1;
                free_idx = IDX_BITS'(i);
            end
        end
        count = CNT_BITS'($countones(valid_reg));
    end

    // Oldest stamp and lowest warp are found by balanced trees; on a tie the
    // left branch, which holds the lower slots, wins.
    always_comb
    begin
        for (int n = 0; n < 2 * LEAVES; n++)
        begin
            old_node_ok[n] = 1'b0;
            old_node_idx[n] = '0;
            old_node_stamp[n] = '0;
            low_node_ok[n] = 1'b0;
            low_node_idx[n] = '0;
            low_node_warp[n] = '0;
        end
        for (int i = 0; i < LEAVES; i++)
        begin
            if (i < TABLE_DEPTH)
            begin
                old_node_ok[LEAVES + i] = valid_reg[i];
                old_node_stamp[LEAVES + i] = stamp_reg[i];
                low_node_ok[LEAVES + i] = valid_reg[i] && slot_lw_ok[i];
                low_node_warp[LEAVES + i] = slot_lw[i];
            end
            old_node_idx[LEAVES + i] = IDX_BITS'(i);
            low_node_idx[LEAVES + i] = IDX_BITS'(i);
        end
        for (int k = LEAVES - 1; k >= 1; k--)
        begin
            if (old_node_ok[2*k] && (!old_node_ok[2*k+1]
                || old_node_stamp[2*k] <= old_node_stamp[2*k+1]))
            begin
                old_node_ok[k] = 1'b1;
                old_node_idx[k] = old_node_idx[2*k];
                old_node_stamp[k] = old_node_stamp[2*k];
            end
            else
            begin
                old_node_ok[k] = old_node_ok[2*k+1];
                old_node_idx[k] = old_node_idx[2*k+1];
                old_node_stamp[k] = old_node_stamp[2*k+1];
            end
            if (low_node_ok[2*k] && (!low_node_ok[2*k+1]
                || low_node_warp[2*k] <= low_node_warp[2*k+1]))
            begin
                low_node_ok[k] = 1'b1;
                low_node_idx[k] = low_node_idx[2*k];
                low_node_warp[k] = low_node_warp[2*k];
            end
            else
            begin
                low_node_ok[k] = low_node_ok[2*k+1];
                low_node_idx[k] = low_node_idx[2*k+1];
                low_node_warp[k] = low_node_warp[2*k+1];
            end
        end
        old_found = old_node_ok[1];
        old_idx = old_node_idx[1];
        low_found = low_node_ok[1];
        low_idx = low_node_idx[1];
        low_warp = low_node_warp[1];
    end

    always_comb
    begin
        eff_limit = ({1'b0, CNT_BITS'(limit)} > (CNT_BITS+1)'(TABLE_DEPTH))
            ? (CNT_BITS+1)'(TABLE_DEPTH) : (CNT_BITS+1)'(limit);
        do_alloc = !hit && has_free && ({1'b0, count} < eff_limit);
        use_greedy = (policy == POLICY_GREEDY) || (policy == POLICY_HYBRID && hybrid);
        fallback = (policy == POLICY_GREEDY);
        pick_new_greedy = 1'b0;
        if (use_greedy && gr_found)
        begin
            pick_ok = 1'b1;
            pick_idx = gr_idx;
        end
        else if (use_greedy && low_found)
        begin
            pick_ok = 1'b1;
            pick_idx = low_idx;
            pick_new_greedy = 1'b1;
        end
        else if (!use_greedy || fallback)
        begin
            pick_ok = old_found;
            pick_idx = old_idx;
        end
        else
        begin
            pick_ok = 1'b0;
            pick_idx = old_idx;
        end
        valid_after = valid_reg;
        if (cmd_reg == CMD_INSERT && do_alloc)
        begin
            valid_after[free_idx] = 1'b1;
        end
        else if (cmd_reg == CMD_POP && pick_ok)
        begin
            valid_after[pick_idx] = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg <= req_command;
            key_in_reg <= {req_space, req_address};
            size_in_reg <= req_size;
            sect_in_reg <= req_sectors;
            warp_in_reg <= wsat;
        end
        if (cmd.execute && cmd_reg == CMD_INSERT)
        begin
            if (hit)
            begin
                if (size_in_reg > size_reg[hit_idx])
                begin
                    size_reg[hit_idx] <= size_in_reg;
                end
                sect_reg[hit_idx] <= sect_reg[hit_idx] | sect_in_reg;
                warps_reg[hit_idx][warp_in_reg] <= 1'b1;
            end
            else if (do_alloc)
            begin
                key_reg[free_idx] <= key_in_reg;
                size_reg[free_idx] <= size_in_reg;
                sect_reg[free_idx] <= sect_in_reg;
                warps_reg[free_idx] <= WARP_COUNT'(1) << warp_in_reg;
                stamp_reg[free_idx] <= counter_reg;
            end
        end
        if (cmd.out_load)
        begin
            rsp_accepted <= (cmd_reg == CMD_INSERT) && (hit || do_alloc);
            rsp_merged <= (cmd_reg == CMD_INSERT) && hit;
            rsp_pop_valid <= (cmd_reg == CMD_POP) && pick_ok;
            if (cmd_reg == CMD_POP && pick_ok)
            begin
                rsp_address <= key_reg[pick_idx][ADDR_BITS-1:0];
                rsp_space <= key_reg[pick_idx][KEY_BITS-1:ADDR_BITS];
                rsp_size <= size_reg[pick_idx];
                rsp_sectors <= sect_reg[pick_idx];
                rsp_warps <= 64'(warps_reg[pick_idx]);
            end
            else
            begin
                rsp_address <= '0;
                rsp_space <= '0;
                rsp_size <= '0;
                rsp_sectors <= '0;
                rsp_warps <= '0;
            end
            rsp_empty <= (valid_after == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            counter_reg <= '0;
            greedy_reg <= '0;
        end
        else if (cmd.execute)
        begin
            valid_reg <= valid_after;
            if (cmd_reg == CMD_INSERT && do_alloc)
            begin
                counter_reg <= counter_reg + STAMP_BITS'(1);
            end
            if (cmd_reg == CMD_POP && pick_new_greedy)
            begin
                greedy_reg <= low_warp;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.execute && cmd_reg == CMD_INSERT && do_alloc |=> valid_reg != '0)
        else $error("Allocation left table empty.");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.execute && hit |-> !do_alloc)
        else $error("Merge and allocate together.");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.execute && cmd_reg == CMD_POP && pick_ok |-> valid_reg[pick_idx])
        else $error("Pop selected an empty slot.");

endmodule

@@ verif/rrct_table_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Coalescing table checker
// Watches the request, result and register ports, keeps its own copy of the
// table, predicts the result of every request transaction and compares each
// result transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module rrct_table_checker
    import rrct_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    rrct_req_if                   req,
    rrct_rsp_if                   rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [31:0]           pwdata,
    output int                    mismatches,
    output int                    outstanding
);

    localparam int DEPTH = 32;

    typedef struct packed {
        logic        accepted;
        logic        merged;
        logic        pop_valid;
        logic [47:0] address;
        logic [3:0]  space;
        logic [7:0]  size;
        logic [3:0]  sectors;
        logic [63:0] warps;
        logic        now_empty;
    } table_result_t;

    logic        held[DEPTH];
    logic [51:0] held_key[DEPTH];
    logic [7:0]  held_size[DEPTH];
    logic [3:0]  held_sectors[DEPTH];
    logic [63:0] held_warps[DEPTH];
    logic [31:0] held_stamp[DEPTH];
    logic [31:0] alloc_count;
    logic [5:0]  greedy_id;
    logic [1:0]  policy;
    logic        hybrid;
    logic [5:0]  limit;

    table_result_t pending_results[$];

    function automatic int oldest_slot();
        int best;
        best = -1;
        for (int i = 0; i < DEPTH; i++)
            if (held[i] && (best < 0 || held_stamp[i] < held_stamp[best]))
                best = i;
        return best;
    endfunction

    task automatic greedy_slot(output int pick);
        int lowest;
        int best;
        lowest = 64;
        best = -1;
        pick = -1;
        for (int i = 0; i < DEPTH; i++) begin
            if (held[i]) begin
                if (held_warps[i][greedy_id]) begin
                    pick = i;
                    return;
                end
                for (int w = 0; w < lowest; w++) begin
                    if (held_warps[i][w]) begin
                        lowest = w;
                        best = i;
                        break;
                    end
                end
            end
        end
        if (best >= 0)
            greedy_id = lowest[5:0];
        pick = best;
    endtask

    task automatic apply_request(output table_result_t r);
        logic [51:0] key;
        int hit;
        int free;
        int count;
        int cap;
        int pick;
        r = '0;
        if (req.command == CMD_INSERT) begin
            key = {req.space, req.address};
            hit = -1;
            free = -1;
            count = 0;
            cap = (limit > DEPTH) ? DEPTH : limit;
            for (int i = 0; i < DEPTH; i++) begin
                if (held[i]) begin
                    count++;
                    if (hit < 0 && held_key[i] == key)
                        hit = i;
                end else if (free < 0) begin
                    free = i;
                end
            end
            if (hit >= 0) begin
                if (req.req_size > held_size[hit])
                    held_size[hit] = req.req_size;
                held_sectors[hit] |= req.sectors;
                held_warps[hit][req.warp] = 1'b1;
                r.accepted = 1'b1;
                r.merged = 1'b1;
            end else if (count < cap && free >= 0) begin
                held[free] = 1'b1;
                held_key[free] = key;
                held_size[free] = req.req_size;
                held_sectors[free] = req.sectors;
                held_warps[free] = 64'd1 << req.warp;
                held_stamp[free] = alloc_count;
                alloc_count++;
                r.accepted = 1'b1;
            end
        end else begin
            if (policy == POLICY_GREEDY) begin
                greedy_slot(pick);
                if (pick < 0)
                    pick = oldest_slot();
            end else if (policy == POLICY_HYBRID && hybrid) begin
                greedy_slot(pick);
            end else begin
                pick = oldest_slot();
            end
            if (pick >= 0) begin
                r.pop_valid = 1'b1;
                r.address = held_key[pick][47:0];
                r.space = held_key[pick][51:48];
                r.size = held_size[pick];
                r.sectors = held_sectors[pick];
                r.warps = held_warps[pick];
                held[pick] = 1'b0;
            end
        end
        r.now_empty = 1'b1;
        for (int i = 0; i < DEPTH; i++)
            if (held[i])
                r.now_empty = 1'b0;
    endtask

    always @(posedge clk or negedge rst_n) begin
        table_result_t predicted;
        table_result_t observed;
        if (!rst_n) begin
            for (int i = 0; i < DEPTH; i++)
                held[i] = 1'b0;
            alloc_count = '0;
            greedy_id = '0;
            policy = POLICY_OLDEST;
            hybrid = 1'b0;
            limit = 6'd32;
            mismatches = 0;
            pending_results.delete();
            outstanding = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr)
                    REG_POLICY: policy = pwdata[1:0];
                    REG_HYBRID: hybrid = pwdata[0];
                    REG_LIMIT:  limit = pwdata[5:0];
                    default: ;
                endcase
            end
            if (rsp.valid && rsp.ready) begin
                observed = '{rsp.accepted, rsp.merged, rsp.pop_valid, rsp.out_address,
                             rsp.out_space, rsp.out_size, rsp.out_sectors, rsp.out_warps,
                             rsp.now_empty};
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result transaction with none expected", $realtime);
                end else begin
                    predicted = pending_results.pop_front();
                    if (observed !== predicted) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: result mismatch", $realtime);
                            $display("  expected acc %b mrg %b pop %b addr %h sp %h size %h",
                                     predicted.accepted, predicted.merged,
                                     predicted.pop_valid, predicted.address,
                                     predicted.space, predicted.size);
                            $display("           sect %h warps %h empty %b",
                                     predicted.sectors, predicted.warps,
                                     predicted.now_empty);
                            $display("  actual   acc %b mrg %b pop %b addr %h sp %h size %h",
                                     observed.accepted, observed.merged,
                                     observed.pop_valid, observed.address,
                                     observed.space, observed.size);
                            $display("           sect %h warps %h empty %b",
                                     observed.sectors, observed.warps, observed.now_empty);
                        end
                    end
                end
            end
            if (req.valid && req.ready) begin
                apply_request(predicted);
                pending_results = {pending_results, predicted};
            end
            outstanding = pending_results.size();
        end
    end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Coalescing table testbench
// Drives directed and random insert and pop transactions through several
// register settings with random idling on both channels; the checker
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
    import rrct_pkg::*;

    localparam int POOL = 40;
    localparam int PHASES = 7;
    localparam int PHASE_ITEMS = 90;
    localparam int IDLE_LIMIT = 4000;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_BITS-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;
    int mismatches;
    int outstanding;
    int idle_cycles = 0;
    bit burst;

    logic [47:0] pool_address[POOL];
    logic [3:0]  pool_space[POOL];

    int phase_policy[PHASES] = '{0, 1, 2, 2, 3, 1, 2};
    int phase_hybrid[PHASES] = '{0, 0, 1, 0, 1, 1, 1};
    int phase_limit[PHASES]  = '{32, 4, 1, 0, 63, 16, 32};
    int phase_pop[PHASES]    = '{30, 40, 40, 50, 25, 45, 40};
    int phase_span[PHASES]   = '{40, 8, 3, 6, 40, 20, 12};

    rrct_req_if #(.ADDR_BITS(48)) req_ch();
    rrct_rsp_if #(.ADDR_BITS(48)) rsp_ch();

    read_request_coalescing_table_unit dut (
        .clk(clk), .rst_n(rst_n), .req(req_ch), .rsp(rsp_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    rrct_table_checker checker_inst (
        .clk(clk), .rst_n(rst_n), .req(req_ch), .rsp(rsp_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata), .mismatches(mismatches),
        .outstanding(outstanding)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
            || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic write_register(input logic [PADDR_BITS-1:0] addr, input int value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_request(input logic cmd, input logic [47:0] addr,
                                input logic [3:0] space, input logic [7:0] size,
                                input logic [3:0] sect, input logic [5:0] warp);
        int gap;
        bit taken;
        gap = burst ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.command <= cmd;
        req_ch.address <= addr;
        req_ch.space <= space;
        req_ch.req_size <= size;
        req_ch.sectors <= sect;
        req_ch.warp <= warp;
        do begin
            @(negedge clk);
            taken = req_ch.ready;
            @(posedge clk);
        end while (!taken);
        if ($urandom_range(0, 19) == 0)
            burst = !burst;
    endtask

    task automatic random_request(input int pop_pct, input int span);
        int idx;
        logic [47:0] addr;
        logic [3:0] space;
        logic [5:0] warp;
        idx = $urandom_range(0, span - 1);
        addr = pool_address[idx];
        space = pool_space[idx];
        if ($urandom_range(0, 9) == 0) begin
            addr = 48'({$urandom, $urandom});
            space = 4'($urandom);
        end
        warp = ($urandom_range(0, 1) == 0) ? 6'($urandom_range(0, 7))
                                           : 6'($urandom_range(0, 63));
        send_request(($urandom_range(0, 99) < pop_pct) ? CMD_POP : CMD_INSERT,
                     addr, space, 8'($urandom), 4'($urandom), warp);
    endtask

    task automatic settle();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        rsp_ch.ready <= 1'b0;
        wait (rst_n);
        forever begin
            int gap;
            bit taken;
            gap = burst ? 0 : $urandom_range(0, 3);
            @(posedge clk);
            if (gap > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do begin
                @(negedge clk);
                taken = rsp_ch.valid;
                if (!taken)
                    @(posedge clk);
            end while (!taken);
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        burst = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.command = CMD_INSERT;
        req_ch.address = '0;
        req_ch.space = '0;
        req_ch.req_size = '0;
        req_ch.sectors = '0;
        req_ch.warp = '0;
        for (int i = 0; i < POOL; i++) begin
            pool_address[i] = 48'({$urandom, $urandom});
            pool_space[i] = 4'($urandom);
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        send_request(CMD_POP, '0, '0, '0, '0, '0);
        send_request(CMD_INSERT, '0, 4'h0, 8'h00, 4'h0, 6'd0);
        send_request(CMD_INSERT, '1, 4'hf, 8'hff, 4'hf, 6'd63);
        send_request(CMD_INSERT, '0, 4'h0, 8'h10, 4'h1, 6'd5);
        send_request(CMD_INSERT, '0, 4'h0, 8'h08, 4'h8, 6'd5);
        send_request(CMD_INSERT, '1, 4'hf, 8'h01, 4'h0, 6'd0);
        send_request(CMD_INSERT, '1, 4'h0, 8'h20, 4'h2, 6'd7);
        send_request(CMD_INSERT, 48'h5555_5555_5555, 4'h5, 8'h55, 4'h5, 6'd21);
        send_request(CMD_INSERT, 48'haaaa_aaaa_aaaa, 4'ha, 8'haa, 4'ha, 6'd42);
        repeat (6) send_request(CMD_POP, '0, '0, '0, '0, '0);
        settle();

        for (int p = 0; p < PHASES; p++) begin
            write_register(REG_POLICY, phase_policy[p]);
            write_register(REG_HYBRID, phase_hybrid[p]);
            write_register(REG_LIMIT, phase_limit[p]);
            for (int n = 0; n < PHASE_ITEMS; n++)
                random_request((n < PHASE_ITEMS / 2) ? phase_pop[p] / 2
                                                     : phase_pop[p] + 20,
                               phase_span[p]);
            settle();
        end

        repeat (10) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/rrct_pkg.sv
hw/rtl/rrct_if.sv
hw/rtl/rrct_ctrl.sv
hw/rtl/rrct_datapath.sv
hw/rtl/read_request_coalescing_table_unit.sv
verif/rrct_table_checker.sv
verif/tb.sv
